// ===== rtl/core/epl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_pkg - shared definitions for the exclusion-process lattice core
// Field widths, opcode, event and register index codes, and the request and
// response types of the shared compare unit.
// ----------------------------------------------------------------------------
package epl_pkg;

   // field widths fixed by the beat formats
   localparam int SITE_W     = 10;
   localparam int DRAW_W     = 16;
   localparam int RATE_W     = 17;
   localparam int SCOUNT_W   = 11;
   localparam int OP_W       = 2;
   localparam int EV_W       = 3;
   localparam int VISIT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // opcodes
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd0;
   localparam logic [OP_W-1:0] OP_SWEEP = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd3;

   // event codes
   localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
   localparam logic [EV_W-1:0] EV_ENTRY = 3'd1;
   localparam logic [EV_W-1:0] EV_HOP   = 3'd2;
   localparam logic [EV_W-1:0] EV_EXIT  = 3'd3;
   localparam logic [EV_W-1:0] EV_RANGE = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SITE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_RATE  = 2'd2;

   // compare unit request and response
   typedef struct packed {
      logic [DRAW_W-1:0] draw;
      logic [RATE_W-1:0] rate;
   } cmp_req_type;

   typedef struct packed {
      logic below;
   } cmp_rsp_type;

endpackage

// ===== rtl/core/epl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module epl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/epl_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_alu - shared arithmetic unit of the lattice core
// Draw-against-rate compare, saturating counter increment and the clamp of a
// counter to the 32-bit visit count.
// ----------------------------------------------------------------------------
module epl_alu #(
   parameter int COUNT_WIDTH = 32
) (
   input  epl_pkg::cmp_req_type        cmp_req,
   output epl_pkg::cmp_rsp_type        cmp_rsp,
   input  logic                        inc_bit,
   input  logic [COUNT_WIDTH-1:0]      inc_cnt,
   output logic [COUNT_WIDTH-1:0]      inc_out,
   input  logic [COUNT_WIDTH-1:0]      clamp_cnt,
   output logic [epl_pkg::VISIT_W-1:0] clamp_out
);
   import epl_pkg::*;

   // draw < rate, rate may reach 65536
   always_comb begin
      cmp_rsp.below = ({1'b0, cmp_req.draw} < cmp_req.rate);
   end

   // add the occupancy bit, stop at all ones
   always_comb begin
      if (inc_bit && (inc_cnt != {COUNT_WIDTH{1'b1}})) begin
         inc_out = inc_cnt + COUNT_WIDTH'(1);
      end else begin
         inc_out = inc_cnt;
      end
   end

   // clamp to the visit count width
   generate
      if (COUNT_WIDTH > VISIT_W) begin : g_clamp
         assign clamp_out = (|clamp_cnt[COUNT_WIDTH-1:VISIT_W]) ? {VISIT_W{1'b1}}
                                                              : clamp_cnt[VISIT_W-1:0];
      end else begin : g_extend
         assign clamp_out = VISIT_W'(clamp_cnt);
      end
   endgenerate

endmodule

// ===== rtl/core/exclusion_process_lattice_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exclusion_process_lattice_core - TASEP lattice with per-site visit counters
// Occupancy lattice and counters in RAM, worked by one sequencer around a
// shared compare and increment unit.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake           | Payload
// req     | in  | req_tvalid/tready   | tuser opcode, tdata site/draw/occupancy
// rsp     | out | rsp_tvalid/tready   | tuser event, tdata occupancy/visit count
// csr     | in  | csr_valid/ready     | csr_index, csr_data
//
// Move and read run through RDA, RDB, DEC (and HOP for a hop) to PUT, set by
// the two reads through the single lattice RAM read port and the write-back.
// Load runs through LOAD to PUT, any other beat to an out-of-range site goes
// straight to PUT. Sweep first walks the counter RAM one site a cycle over the
// sites in use, then ends like a read (straight to PUT out of range).
// After reset a clearing pass over all MAX_SITES addresses zeroes both RAMs;
// no request is taken meanwhile, register writes are.
// The result sits in an output register; a stalled rsp holds the sequencer in
// its hand-off state.
// ----------------------------------------------------------------------------
module exclusion_process_lattice_core #(
   parameter int MAX_SITES   = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request beats
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [epl_pkg::REQ_DATA_W-1:0] req_tdata,  // site, uniform_draw, occupancy_in
   input  logic [epl_pkg::OP_W-1:0]       req_tuser,  // opcode
   // response beats
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [epl_pkg::RSP_DATA_W-1:0] rsp_tdata,  // occupancy, visit_count
   output logic [epl_pkg::EV_W-1:0]       rsp_tuser,  // event_res
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [epl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [epl_pkg::RATE_W-1:0]     csr_data
);
   import epl_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SITES);

   // sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SWEEP = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_RDB   = 4'd4;
   localparam logic [3:0] S_DEC   = 4'd5;
   localparam logic [3:0] S_HOP   = 4'd6;
   localparam logic [3:0] S_LOAD  = 4'd7;
   localparam logic [3:0] S_PUT   = 4'd8;

   logic [3:0]             state_ff, state_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [SITE_W-1:0]      site_ff, site_in;
   logic [DRAW_W-1:0]      draw_ff, draw_in;
   logic                   occ_ff, occ_in;
   logic                   range_ff, range_in;
   logic [SCOUNT_W-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic                   wb_pend_ff, wb_pend_in;
   logic [ADDR_W-1:0]      wb_addr_ff, wb_addr_in;
   logic                   bit_i_ff, bit_i_in;
   logic [COUNT_WIDTH-1:0] cnt_i_ff, cnt_i_in;
   logic [EV_W-1:0]        res_ev_ff, res_ev_in;
   logic                   res_occ_ff, res_occ_in;
   logic [COUNT_WIDTH-1:0] res_cnt_ff, res_cnt_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [EV_W-1:0]        rsp_ev_ff, rsp_ev_in;
   logic                   rsp_occ_ff, rsp_occ_in;
   logic [VISIT_W-1:0]     rsp_visit_ff, rsp_visit_in;
   logic [SCOUNT_W-1:0]    site_count_ff;
   logic [RATE_W-1:0]      entry_rate_ff;
   logic [RATE_W-1:0]      exit_rate_ff;

   logic [SCOUNT_W-1:0]    sites_used;
   logic                   is_first;
   logic                   is_last;
   logic                   req_fire;
   logic                   req_in_range;

   logic                   lat_we, lat_wdata, lat_rdata;
   logic [ADDR_W-1:0]      lat_waddr, lat_raddr;
   logic                   cnt_we;
   logic [ADDR_W-1:0]      cnt_waddr, cnt_raddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

   cmp_req_type            cmp_req;
   cmp_rsp_type            cmp_rsp;
   logic [COUNT_WIDTH-1:0] inc_out;
   logic [VISIT_W-1:0]     visit_clamp;

   // register port, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= SCOUNT_W'(1024);
         entry_rate_ff <= '0;
         exit_rate_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SITE_COUNT: site_count_ff <= csr_data[SCOUNT_W-1:0];
            CSR_ENTRY_RATE: entry_rate_ff <= csr_data;
            CSR_EXIT_RATE:  exit_rate_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sites in use and position of the addressed site
   assign sites_used   = (32'(site_count_ff) > MAX_SITES) ? SCOUNT_W'(MAX_SITES)
                                                          : site_count_ff;
   assign is_first     = (site_ff == '0);
   assign is_last      = ({1'b0, site_ff} == (sites_used - SCOUNT_W'(1)));
   assign req_in_range = ({1'b0, req_tdata[SITE_W-1:0]} < sites_used);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // shared unit hook-up: entry rate only for an empty first site
   assign cmp_req.draw = draw_ff;
   assign cmp_req.rate = (is_first && !bit_i_ff) ? entry_rate_ff : exit_rate_ff;

   epl_alu #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_alu (
      .cmp_req   (cmp_req),
      .cmp_rsp   (cmp_rsp),
      .inc_bit   (lat_rdata),
      .inc_cnt   (cnt_rdata),
      .inc_out   (inc_out),
      .clamp_cnt (res_cnt_ff),
      .clamp_out (visit_clamp)
   );

   epl_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SITES)
   ) u_lattice_ram (
      .clock   (clock),
      .wr_en   (lat_we),
      .wr_addr (lat_waddr),
      .wr_data (lat_wdata),
      .rd_addr (lat_raddr),
      .rd_data (lat_rdata)
   );

   epl_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_SITES)
   ) u_counter_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      site_in       = site_ff;
      draw_in       = draw_ff;
      occ_in        = occ_ff;
      range_in      = range_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      wb_pend_in    = 1'b0;
      wb_addr_in    = wb_addr_ff;
      bit_i_in      = bit_i_ff;
      cnt_i_in      = cnt_i_ff;
      res_ev_in     = res_ev_ff;
      res_occ_in    = res_occ_ff;
      res_cnt_in    = res_cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_ev_in     = rsp_ev_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_visit_in  = rsp_visit_ff;

      lat_we    = 1'b0;
      lat_waddr = ADDR_W'(site_ff);
      lat_wdata = 1'b0;
      lat_raddr = ADDR_W'(site_ff);
      cnt_we    = 1'b0;
      cnt_waddr = ADDR_W'(site_ff);
      cnt_wdata = '0;
      cnt_raddr = ADDR_W'(site_ff);

      unique case (state_ff)
         // zero both RAMs after reset
         S_CLEAR: begin
            lat_we    = 1'b1;
            lat_waddr = clr_addr_ff;
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(MAX_SITES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               op_in        = req_tuser;
               site_in      = req_tdata[SITE_W-1:0];
               draw_in      = req_tdata[SITE_W+DRAW_W-1:SITE_W];
               occ_in       = req_tdata[SITE_W+DRAW_W];
               range_in     = req_in_range;
               sweep_cnt_in = '0;
               res_ev_in    = EV_RANGE;
               res_occ_in   = 1'b0;
               res_cnt_in   = '0;
               if (req_tuser == OP_SWEEP) begin
                  state_in = S_SWEEP;
               end else if (!req_in_range) begin
                  state_in = S_PUT;
               end else if (req_tuser == OP_LOAD) begin
                  state_in = S_LOAD;
               end else begin
                  state_in = S_RDA;
               end
            end
         end

         // one site a cycle: read k, write back k-1
         S_SWEEP: begin
            cnt_we    = wb_pend_ff;
            cnt_waddr = wb_addr_ff;
            cnt_wdata = inc_out;
            lat_raddr = ADDR_W'(sweep_cnt_ff);
            cnt_raddr = ADDR_W'(sweep_cnt_ff);
            if (sweep_cnt_ff < sites_used) begin
               wb_pend_in   = 1'b1;
               wb_addr_in   = ADDR_W'(sweep_cnt_ff);
               sweep_cnt_in = sweep_cnt_ff + SCOUNT_W'(1);
            end else if (!wb_pend_ff) begin
               state_in = range_ff ? S_RDA : S_PUT;
            end
         end

         S_RDA: begin
            state_in = S_RDB;
         end

         // site bit and counter back; fetch the right neighbour
         S_RDB: begin
            bit_i_in  = lat_rdata;
            cnt_i_in  = cnt_rdata;
            lat_raddr = ADDR_W'(site_ff) + ADDR_W'(1);
            state_in  = S_DEC;
         end

         // move decision, lat_rdata holds the neighbour
         S_DEC: begin
            res_ev_in  = EV_NONE;
            res_occ_in = bit_i_ff;
            res_cnt_in = cnt_i_ff;
            state_in   = S_PUT;
            if (op_ff == OP_MOVE) begin
               if (is_first && !bit_i_ff && cmp_rsp.below) begin
                  lat_we     = 1'b1;
                  lat_wdata  = 1'b1;
                  res_ev_in  = EV_ENTRY;
                  res_occ_in = 1'b1;
               end else if (is_last) begin
                  if (bit_i_ff && cmp_rsp.below) begin
                     lat_we     = 1'b1;
                     res_ev_in  = EV_EXIT;
                     res_occ_in = 1'b0;
                  end
               end else if (bit_i_ff && !lat_rdata) begin
                  lat_we     = 1'b1;
                  res_ev_in  = EV_HOP;
                  res_occ_in = 1'b0;
                  state_in   = S_HOP;
               end
            end
         end

         // second half of a hop
         S_HOP: begin
            lat_we    = 1'b1;
            lat_waddr = ADDR_W'(site_ff) + ADDR_W'(1);
            lat_wdata = 1'b1;
            state_in  = S_PUT;
         end

         S_LOAD: begin
            lat_we     = 1'b1;
            lat_wdata  = occ_ff;
            cnt_we     = 1'b1;
            res_ev_in  = EV_NONE;
            res_occ_in = occ_ff;
            res_cnt_in = '0;
            state_in   = S_PUT;
         end

         // hand the result to the output register
         S_PUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_ev_in     = res_ev_ff;
               rsp_occ_in    = res_occ_ff;
               rsp_visit_in  = visit_clamp;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         wb_pend_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         wb_pend_ff    <= wb_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      site_ff      <= site_in;
      draw_ff      <= draw_in;
      occ_ff       <= occ_in;
      range_ff     <= range_in;
      sweep_cnt_ff <= sweep_cnt_in;
      wb_addr_ff   <= wb_addr_in;
      bit_i_ff     <= bit_i_in;
      cnt_i_ff     <= cnt_i_in;
      res_ev_ff    <= res_ev_in;
      res_occ_ff   <= res_occ_in;
      res_cnt_ff   <= res_cnt_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_visit_ff <= rsp_visit_in;
   end

   // response beat
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VISIT_W - 1)'(0), rsp_visit_ff, rsp_occ_ff};

`ifndef SYNTH
   // a new result only comes out of the hand-off state
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == S_PUT))
      else $error("response raised outside hand-off state");

   // the second hop write always follows the move decision
   a_hop_after_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOP) |-> ($past(state_ff) == S_DEC))
      else $error("hop write without a move decision");

   // nothing is reported while the RAMs are being cleared
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!rsp_tvalid_ff && !req_tready))
      else $error("activity during clearing pass");
`endif

endmodule
